FILE: hw/rtl/long_fir_convolver_assert.svh
// Assertion macros used by the long FIR convolver controller.
`ifndef LONG_FIR_CONVOLVER_ASSERT_SVH
`define LONG_FIR_CONVOLVER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lfc_pkg.sv
// Shared constants, state encoding and control structs of the long FIR convolver.
`default_nettype none

package lfc_pkg;

  localparam int MAX_TAPS_DEF    = 4096;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CIDX_W          = 12;
  localparam int TAPCNT_W        = 13;

  localparam logic [TAPCNT_W-1:0] TAPCNT_RST = TAPCNT_W'(1);

  // request kind carried in in_tuser
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEFF  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic clr_we;     // clearing pass: zero one entry of both memories
    logic coeff_we;   // store coefficient from the current transfer
    logic push;       // advance newest pointer, store sample
    logic mac_init;   // reset tap counter and accumulator
    logic mac_issue;  // read one tap pair into the MAC pipe
    logic out_load;   // round/saturate accumulator into output register
  } cmd_t;

  typedef struct packed {
    logic clr_last;   // clearing pass at last entry
    logic mac_last;   // current issue is the last tap
    logic taps_zero;  // no taps in use
    logic pipe_busy;  // products still in flight
  } sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lfc_datapath.sv
// Datapath: coefficient and history memories, MAC pipeline, rounding and output register.
`default_nettype none

module lfc_datapath
  import lfc_pkg::*;
#(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  input  wire logic                   cfg_we,
  input  wire logic [TAPCNT_W-1:0]    cfg_wdata,
  input  wire logic [CIDX_W-1:0]      coeff_index,
  input  wire logic [SAMPLE_BITS-1:0] coeff_value,
  input  wire logic [SAMPLE_BITS-1:0] sample_in,
  output logic [SAMPLE_BITS-1:0]      sample_out,
  output logic                        clipped
);

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int KW    = $clog2(MAX_TAPS + 1);
  localparam int CW    = (KW > TAPCNT_W) ? KW : TAPCNT_W;
  localparam int IW    = (AW > CIDX_W) ? AW : CIDX_W;
  localparam int PW    = 2 * SAMPLE_BITS;
  localparam int ACC_W = PW + AW + 1;
  localparam int QW    = ACC_W + 1 - (SAMPLE_BITS - 1);

  localparam logic [AW-1:0]    LAST_ADDR  = AW'(MAX_TAPS - 1);
  localparam logic [CW-1:0]    MAX_TAPS_C = CW'(MAX_TAPS);
  localparam logic [IW:0]      MAX_IDX    = (IW + 1)'(MAX_TAPS);
  localparam logic [ACC_W:0]   HALF       = (ACC_W + 1)'(1) << (SAMPLE_BITS - 2);
  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  logic [TAPCNT_W-1:0] tap_count_r;
  logic [CW-1:0]       taps_c;
  logic [KW-1:0]       taps_eff;

  logic [AW-1:0] newest_r;
  logic [AW-1:0] newest_inc;
  logic [AW-1:0] clr_addr_r;
  logic [KW-1:0] k_r;
  logic [AW-1:0] idx_r;

  logic [IW:0]   ci_w;
  logic          ci_ok;

  logic                   c_we;
  logic [AW-1:0]          c_wa;
  logic [SAMPLE_BITS-1:0] c_wd;
  logic                   h_we;
  logic [AW-1:0]          h_wa;
  logic [SAMPLE_BITS-1:0] h_wd;

  logic [SAMPLE_BITS-1:0] coeff_mem [MAX_TAPS];
  logic [SAMPLE_BITS-1:0] hist_mem  [MAX_TAPS];
  logic [SAMPLE_BITS-1:0] coeff_rd_r;
  logic [SAMPLE_BITS-1:0] hist_rd_r;

  logic                    v1_r;
  logic                    v2_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;

  logic [ACC_W:0]          rnd_v;
  logic [QW-1:0]           rnd_q;
  logic                    ovf;
  logic [SAMPLE_BITS-1:0]  sat;

  logic [SAMPLE_BITS-1:0]  sample_out_r;
  logic                    clipped_r;

  // tap count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAPCNT_RST;
    end else if (cfg_we) begin
      tap_count_r <= cfg_wdata;
    end
  end

  assign taps_c   = CW'(tap_count_r);
  assign taps_eff = (taps_c > MAX_TAPS_C) ? MAX_TAPS_C[KW-1:0] : taps_c[KW-1:0];

  assign newest_inc = (newest_r == LAST_ADDR) ? '0 : newest_r + AW'(1);

  assign ci_w  = (IW + 1)'(coeff_index);
  assign ci_ok = (ci_w < MAX_IDX);

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r   <= '0;
      clr_addr_r <= '0;
      k_r        <= '0;
      idx_r      <= '0;
    end else begin
      if (cmd.push) begin
        newest_r <= newest_inc;
      end
      if (cmd.clr_we) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.mac_init) begin
        k_r   <= '0;
        idx_r <= newest_inc;
      end else if (cmd.mac_issue) begin
        k_r   <= k_r + KW'(1);
        idx_r <= (idx_r == '0) ? LAST_ADDR : idx_r - AW'(1);
      end
    end
  end

  // memory write ports: clearing pass has priority
  always_comb begin
    c_we = cmd.clr_we | (cmd.coeff_we & ci_ok);
    c_wa = cmd.clr_we ? clr_addr_r : ci_w[AW-1:0];
    c_wd = cmd.clr_we ? '0 : coeff_value;
    h_we = cmd.clr_we | cmd.push;
    h_wa = cmd.clr_we ? clr_addr_r : newest_inc;
    h_wd = cmd.clr_we ? '0 : sample_in;
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      coeff_mem[c_wa] <= c_wd;
    end
    if (cmd.mac_issue) begin
      coeff_rd_r <= coeff_mem[k_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hist_mem[h_wa] <= h_wd;
    end
    if (cmd.mac_issue) begin
      hist_rd_r <= hist_mem[idx_r];
    end
  end

  // MAC pipe: read -> multiply -> accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(coeff_rd_r) * $signed(hist_rd_r);
    if (cmd.mac_init) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + {{(ACC_W - PW){prod_r[PW-1]}}, prod_r};
    end
  end

  // round half up, then arithmetic shift by SAMPLE_BITS-1
  always_comb begin
    rnd_v = {acc_r[ACC_W-1], acc_r} + HALF;
    rnd_q = rnd_v[ACC_W:SAMPLE_BITS-1];
    ovf   = !(&rnd_q[QW-1:SAMPLE_BITS-1]) && (|rnd_q[QW-1:SAMPLE_BITS-1]);
    if (ovf) begin
      sat = rnd_q[QW-1] ? SAT_MIN : SAT_MAX;
    end else begin
      sat = rnd_q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample_out_r <= sat;
      clipped_r    <= ovf;
    end
  end

  assign sample_out = sample_out_r;
  assign clipped    = clipped_r;

  always_comb begin
    sts.clr_last  = (clr_addr_r == LAST_ADDR);
    sts.mac_last  = (k_r == taps_eff - KW'(1));
    sts.taps_zero = (taps_eff == '0);
    sts.pipe_busy = v1_r | v2_r;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lfc_ctrl.sv
// Controller: clearing pass, request dispatch, tap sequencing and output handshake.
`default_nettype none

`include "long_fir_convolver_assert.svh"

module lfc_ctrl
  import lfc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire logic req_type,
  output logic      out_tvalid,
  input  wire logic out_tready,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (req_type == REQ_COEFF) begin
            cmd.coeff_we = 1'b1;
          end else begin
            cmd.push     = 1'b1;
            cmd.mac_init = 1'b1;
            state_nxt    = sts.taps_zero ? ST_DRAIN : ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cmd.mac_issue = 1'b1;
        if (sts.mac_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last product and a free output slot
        if (!sts.pipe_busy && (!out_valid_r || out_tready)) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & !out_tready);
  end

  assign out_tvalid = out_valid_r;

  `LFC_ASSERT_NOW(a_load_pipe_empty, cmd.out_load, !sts.pipe_busy, "result loaded with products in flight")
  `LFC_ASSERT_NOW(a_load_no_overwrite, cmd.out_load, !out_valid_r || out_tready, "pending result overwritten")
  `LFC_ASSERT_NEXT(a_sample_starts_mac, in_tvalid && in_tready && req_type == REQ_SAMPLE && !sts.taps_zero, state_r == ST_MAC, "sample transfer did not start tap sequence")
  `LFC_ASSERT_NOW(a_issue_excl, cmd.mac_issue, !cmd.push && !cmd.clr_we && !cmd.coeff_we, "tap read overlaps a memory write")

endmodule

`default_nettype wire

FILE: hw/rtl/long_fir_convolver.sv
// Top level of the long FIR convolver: stream packing around controller and datapath.
`default_nettype none

// Direct-form FIR over up to MAX_TAPS taps: y[n] = sum of h[k]*x[n-k] for k below
// tap_count, rounded half up to Q1.15 and saturated, with the clip flag on out_tuser.
// A coefficient transfer (in_tuser = 1) is stored and gives no result. A sample
// transfer (in_tuser = 0) has its result loaded after one read per tap (tap_count
// capped at MAX_TAPS; no reads when tap_count is zero) from the coefficient and history
// memories, then the last multiply, the last accumulate and the rounded load into the
// output register. The next transfer is taken in the cycle after the load.
// One sample is in work at a time; the result sits in an output register, so the next
// transfer is taken while it waits, and the load of the following result stalls until
// the waiting one is taken. After reset the block runs a clearing pass over every entry
// of both memories with in_tready low; cfg writes are taken at any time but belong only
// between items.

module long_fir_convolver
  import lfc_pkg::*;
#(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // in_tdata, low bit up: coeff_index, coeff_value, sample_in, zero pad
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire logic [((CIDX_W + 2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  input  wire logic in_tuser,   // req_type
  // out_tdata, low bit up: sample_out, zero pad
  output logic      out_tvalid,
  input  wire logic out_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  output logic      out_tuser,  // clipped
  input  wire logic cfg_we,
  input  wire logic [TAPCNT_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  logic [CIDX_W-1:0]      coeff_index;
  logic [SAMPLE_BITS-1:0] coeff_value;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic [SAMPLE_BITS-1:0] sample_out;

  assign coeff_index = in_tdata[CIDX_W-1:0];
  assign coeff_value = in_tdata[CIDX_W +: SAMPLE_BITS];
  assign sample_in   = in_tdata[CIDX_W + SAMPLE_BITS +: SAMPLE_BITS];

  always_comb begin
    out_tdata                    = '0;
    out_tdata[SAMPLE_BITS-1:0]   = sample_out;
  end

  lfc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .req_type   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  lfc_datapath #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .coeff_index (coeff_index),
    .coeff_value (coeff_value),
    .sample_in   (sample_in),
    .sample_out  (sample_out),
    .clipped     (out_tuser)
  );

endmodule

`default_nettype wire

FILE: tb/long_fir_convolver_checker.sv
// Scoreboard of the long FIR convolver: predicts every output sample and checks each transfer.
module long_fir_convolver_checker
  import lfc_pkg::*;
#(
  parameter int IN_W  = 48,
  parameter int OUT_W = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                in_tready,
  input  wire logic [IN_W-1:0]     in_tdata,
  input  wire logic                in_tuser,
  input  wire logic                out_tvalid,
  input  wire logic                out_tready,
  input  wire logic [OUT_W-1:0]    out_tdata,
  input  wire logic                out_tuser,
  input  wire logic                cfg_we,
  input  wire logic [TAPCNT_W-1:0] cfg_wdata,
  output int                       fail_count,
  output int                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = SAMPLE_BITS_DEF;

  typedef struct packed {
    logic [SB-1:0] sample;
    logic          clipped;
  } fir_output_t;

  fir_output_t         predicted_outputs [$];
  logic signed [SB-1:0] coeff_mem [MAX_TAPS_DEF];
  logic signed [SB-1:0] history [MAX_TAPS_DEF];
  logic [CIDX_W-1:0]    newest;
  logic [TAPCNT_W-1:0]  tap_setting;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // Sum of h[k]*x[n-k] over the taps in use, rounded half up and saturated to Q1.15.
  function automatic fir_output_t convolve_newest();
    longint            acc;
    longint            q;
    int                n;
    logic [CIDX_W-1:0] slot;
    fir_output_t       r;
    n = (tap_setting > TAPCNT_W'(MAX_TAPS_DEF)) ? MAX_TAPS_DEF : int'(tap_setting);
    acc = 0;
    slot = newest;
    for (int k = 0; k < n; k++) begin
      acc += longint'(coeff_mem[k]) * longint'(history[slot]);
      slot = slot - 1'b1;  // wraps below slot zero
    end
    q = (acc + 64'sd16384) >>> (SB - 1);
    r.clipped = 1'b0;
    if (q > 32767) begin
      q = 32767;
      r.clipped = 1'b1;
    end else if (q < -32768) begin
      q = -32768;
      r.clipped = 1'b1;
    end
    r.sample = q[SB-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [SB-1:0] got,
                                 input logic [SB-1:0] want);
    if (fail_count < 40)
      $display("[%0t] checker: %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    fir_output_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS_DEF; i++) begin
        coeff_mem[i] = '0;
        history[i]   = '0;
      end
      newest      = '0;
      tap_setting = TAPCNT_RST;
      predicted_outputs.delete();
    end else begin
      if (cfg_we)
        tap_setting = cfg_wdata;
      // results leave before the next item's prediction joins the queue
      if (out_tvalid && out_tready) begin
        if (predicted_outputs.size() == 0) begin
          report_mismatch("output transfer with none outstanding", out_tdata[SB-1:0], '0);
        end else begin
          want = predicted_outputs.pop_front();
          if (out_tdata[SB-1:0] !== want.sample)
            report_mismatch("sample_out", out_tdata[SB-1:0], want.sample);
          if (out_tuser !== want.clipped)
            report_mismatch("clipped", SB'(out_tuser), SB'(want.clipped));
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == REQ_COEFF) begin
          coeff_mem[in_tdata[CIDX_W-1:0]] = in_tdata[CIDX_W +: SB];
        end else begin
          newest = newest + 1'b1;
          history[newest] = in_tdata[CIDX_W + SB +: SB];
          predicted_outputs.push_back(convolve_newest());
        end
      end
    end
    outstanding = predicted_outputs.size();
  end

endmodule

FILE: tb/long_fir_convolver_test.sv
// Stimulus and verdict for the long FIR convolver: directed cases, then random phases.
module long_fir_convolver_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lfc_pkg::*;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int IN_W        = ((CIDX_W + 2 * SB + 7) / 8) * 8;
  localparam int OUT_W       = ((SB + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int NUM_PHASES  = 10;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;
  logic                out_tuser;
  logic                cfg_we     = 1'b0;
  logic [TAPCNT_W-1:0] cfg_wdata  = '0;

  int          tx_idle_pct = 7;
  int          rx_idle_pct = 48;
  int          cycle_count = 0;
  int          fail_count;
  int          outstanding;
  int unsigned cur_taps = 1;
  // entry 8 is drawn at run start
  int unsigned phase_taps [NUM_PHASES] = '{5, 1, 31, 0, 2, 4096, 8191, 12, 0, 7};

  long_fir_convolver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  long_fir_convolver_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("long_fir_convolver test failed");
      $finish;
    end
  end

  always @(posedge clk)
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

  // valid stays high between back-to-back transfers; it drops only on an idle cycle
  task automatic send_item(input logic req, input logic [CIDX_W-1:0] ci,
                           input logic [SB-1:0] cv, input logic [SB-1:0] sv);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= IN_W'({sv, cv, ci});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_sample(input logic [SB-1:0] sv);
    send_item(REQ_SAMPLE, CIDX_W'($urandom), SB'($urandom), sv);
  endtask

  task automatic send_coeff(input logic [CIDX_W-1:0] ci, input logic [SB-1:0] cv);
    send_item(REQ_COEFF, ci, cv, SB'($urandom));
  endtask

  // block is idle once every output has arrived and a coefficient write has had time to land
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_taps(input int unsigned v);
    cfg_wdata <= TAPCNT_W'(v);
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_taps = v;
  endtask

  // extremes often enough to drive the sum into saturation
  function automatic logic [SB-1:0] pick_q15();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0001;
      3:       return 16'hFFFF;
      default: return SB'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned       lim;
    int unsigned       n_items;
    logic [CIDX_W-1:0] ci;
    phase_taps[8] = $urandom_range(1, 300);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // one tap after reset, all coefficients zero
    send_sample(16'h7FFF);
    send_coeff(12'd0, 16'h8000);
    send_sample(16'h8000);              // +1.0 product saturates
    send_sample(16'h7FFF);              // exact product 0x8001, no clip
    send_sample(16'h0001);              // product is exactly -1 LSB, no rounding
    send_sample(16'h0000);
    send_coeff(12'hFFF, 16'h7FFF);      // top tap position
    send_coeff(12'd1, 16'h8000);
    settle();
    write_taps(2);
    send_sample(16'h8000);
    send_sample(16'h8000);              // two full-scale products
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);              // negative saturation
    settle();
    write_taps(0);                      // no taps: zero output
    send_sample(16'h1234);
    send_coeff(12'd2, 16'h0001);
    send_sample(16'hFFFF);
    settle();
    write_taps(8191);                   // above the tap limit
    send_sample(16'h7FFF);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        tx_idle_pct = 7;
        rx_idle_pct = 48;
      end else if (p < 7) begin
        tx_idle_pct = 48;
        rx_idle_pct = 7;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_taps(phase_taps[p]);
      lim = (phase_taps[p] == 0) ? 1 :
            (phase_taps[p] > MAX_TAPS_DEF) ? MAX_TAPS_DEF : phase_taps[p];
      n_items = (phase_taps[p] > 1000) ? 8 : 14;
      repeat (n_items) begin
        if ($urandom_range(0, 99) < 35) begin
          ci = ($urandom_range(0, 3) == 0) ? CIDX_W'($urandom)
                                           : CIDX_W'($urandom_range(0, lim - 1));
          send_coeff(ci, pick_q15());
        end else begin
          send_sample(pick_q15());
        end
      end
      settle();
    end

    repeat (cur_taps + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("long_fir_convolver test passed");
    end else begin
      $display("long_fir_convolver test failed");
    end
    $finish;
  end

endmodule
